// ----- rtl/lzd_pkg.sv -----
// Shared types and constants of the LZSS stream decompressor.
// Used by the front parser, the command queue, the copy engine and the top level.
package lzd_pkg;

  // History window and token format
  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int DIST_W            = 12;
  localparam int LEN_W             = 5;
  localparam int LEN_W_NIB         = 4;
  localparam int REM_W             = 24;
  localparam int HDR_BYTES         = 4;
  localparam int FLAG_TOKENS       = 8;
  localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;

  // Command kinds passed from parser to copy engine
  typedef enum logic {
    CMD_LIT,
    CMD_MATCH
  } lzd_kind_t;

  // One queued command: a literal byte or a back-reference copy
  typedef struct packed {
    logic              clr_ptr;  // restart the history pointer at zero first
    lzd_kind_t         kind;
    logic              done;     // last byte of this command ends the stream
    logic [LEN_W-1:0]  count;    // bytes to emit (already clipped to the length)
    logic [DIST_W-1:0] data;     // literal in the low byte, or distance minus one
  } lzd_cmd_t;

endpackage

// ----- rtl/lz77_stream_decompressor.sv -----
// LZSS stream decompressor (4 KiB window), one compressed byte per input word.
// Flow: a literal byte is queued as a command, then loaded into the output register;
// a copy is queued on its second token byte, reads history, then emits its bytes.
// Throughput: input is taken every cycle while the command queue has room; the
// copy engine gives one output byte per cycle while the output is not stalled, after a start state per copy.
// Reset: synchronous rst_n clears parser, queue and pointers; history RAM is not cleared.
module lz77_stream_decompressor import lzd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_stream_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_stream_done
);

  logic     push;
  lzd_cmd_t push_cmd;
  logic     pop;
  lzd_cmd_t head_cmd;
  logic     q_full;
  logic     q_empty;

  // Parse the compressed stream into commands
  lzd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_stream_start (in_stream_start),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Decouple parser and copy engine
  lzd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Carry out literals and copies
  lzd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_stream_done (out_stream_done)
  );

endmodule

// ----- rtl/lzd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lzd_queue.sv -----
// Small register FIFO of parser commands between the front and the back.
// Depends on lzd_pkg for the command type.
module lzd_queue import lzd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lzd_cmd_t push_cmd,
  input  logic     pop,
  output lzd_cmd_t head_cmd,
  output logic     full,
  output logic     empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lzd_cmd_t       slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r,  count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/lzd_front.sv -----
// Front parser: takes compressed bytes, walks header, flag bytes and tokens,
// and queues literal and copy commands. Depends on lzd_pkg.
module lzd_front import lzd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_stream_start,
  input  logic       q_full,
  output logic       push,
  output lzd_cmd_t   push_cmd
);

  logic [2:0]       hdr_cnt_r,   hdr_cnt_nxt;
  logic [REM_W-1:0] remain_r,    remain_nxt;
  logic [7:0]       flag_bits_r, flag_bits_nxt;
  logic [3:0]       flags_left_r, flags_left_nxt;
  logic             exp_second_r, exp_second_nxt;
  logic [7:0]       tok_high_r,  tok_high_nxt;
  logic             clr_pend_r,  clr_pend_nxt;

  logic             accept;
  logic [2:0]       hdr_cnt;
  logic [REM_W-1:0] remain;
  logic [7:0]       flag_bits;
  logic [3:0]       flags_left;
  logic             exp_second;
  logic [7:0]       tok_high;
  logic [LEN_W-1:0] match_len;
  logic [LEN_W-1:0] emit_cnt;
  logic [REM_W-1:0] remain_after;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Apply a stream restart before the byte is parsed
  always_comb begin
    hdr_cnt    = in_stream_start ? '0 : hdr_cnt_r;
    remain     = in_stream_start ? '0 : remain_r;
    flag_bits  = in_stream_start ? '0 : flag_bits_r;
    flags_left = in_stream_start ? '0 : flags_left_r;
    exp_second = in_stream_start ? 1'b0 : exp_second_r;
    tok_high   = in_stream_start ? '0 : tok_high_r;
  end

  // Clip each token's output to what the stream still owes
  always_comb begin
    match_len = LEN_W'(tok_high[7:4]) + LEN_BIAS;
    if (exp_second) begin
      emit_cnt = (remain < REM_W'(match_len)) ? remain[LEN_W-1:0] : match_len;
    end else begin
      emit_cnt = LEN_W'(1);
    end
    remain_after = remain - REM_W'(emit_cnt);
  end

  // Classify the accepted byte
  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    remain_nxt     = remain_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    exp_second_nxt = exp_second_r;
    tok_high_nxt   = tok_high_r;
    clr_pend_nxt   = clr_pend_r;
    push           = 1'b0;
    push_cmd.clr_ptr = clr_pend_r || in_stream_start;
    push_cmd.kind    = CMD_LIT;
    push_cmd.done    = (remain_after == '0);
    push_cmd.count   = emit_cnt;
    push_cmd.data    = DIST_W'(in_byte);
    if (accept) begin
      hdr_cnt_nxt    = hdr_cnt;
      remain_nxt     = remain;
      flag_bits_nxt  = flag_bits;
      flags_left_nxt = flags_left;
      exp_second_nxt = exp_second;
      tok_high_nxt   = tok_high;
      clr_pend_nxt   = clr_pend_r || in_stream_start;
      if (hdr_cnt < 3'(HDR_BYTES)) begin
        // Header: type byte first, then the 24-bit length, low byte first
        case (hdr_cnt[1:0])
          2'd1:    remain_nxt = remain | REM_W'(in_byte);
          2'd2:    remain_nxt = remain | (REM_W'(in_byte) << 8);
          2'd3:    remain_nxt = remain | (REM_W'(in_byte) << 16);
          default: remain_nxt = remain;
        endcase
        hdr_cnt_nxt = hdr_cnt + 3'd1;
      end else if (remain == '0) begin
        // Stream finished: drop the byte
      end else if (flags_left == '0) begin
        flag_bits_nxt  = in_byte;
        flags_left_nxt = 4'(FLAG_TOKENS);
      end else if (exp_second) begin
        push           = 1'b1;
        push_cmd.kind  = CMD_MATCH;
        push_cmd.data  = {tok_high[3:0], in_byte};
        exp_second_nxt = 1'b0;
        remain_nxt     = remain_after;
        flag_bits_nxt  = {flag_bits[6:0], 1'b0};
        flags_left_nxt = flags_left - 4'd1;
        clr_pend_nxt   = 1'b0;
      end else if (flag_bits[7]) begin
        tok_high_nxt   = in_byte;
        exp_second_nxt = 1'b1;
      end else begin
        push           = 1'b1;
        remain_nxt     = remain_after;
        flag_bits_nxt  = {flag_bits[6:0], 1'b0};
        flags_left_nxt = flags_left - 4'd1;
        clr_pend_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r    <= '0;
      remain_r     <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      exp_second_r <= 1'b0;
      tok_high_r   <= '0;
      clr_pend_r   <= 1'b0;
    end else begin
      hdr_cnt_r    <= hdr_cnt_nxt;
      remain_r     <= remain_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      exp_second_r <= exp_second_nxt;
      tok_high_r   <= tok_high_nxt;
      clr_pend_r   <= clr_pend_nxt;
    end
  end

endmodule

// ----- rtl/lzd_back.sv -----
// Copy engine: pops commands, writes every output byte into the history RAM
// and drives the output register. Depends on lzd_pkg and lzd_ram.
module lzd_back import lzd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lzd_cmd_t   head_cmd,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_stream_done
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_MATCH
  } state_t;

  state_t            state_r,   state_nxt;
  logic [AW-1:0]     wp_r,      wp_nxt;
  logic [LEN_W-1:0]  cnt_r,     cnt_nxt;
  logic [DIST_W-1:0] dist_r,    dist_nxt;
  logic              done_r,    done_nxt;
  logic              first_r,   first_nxt;
  logic [7:0]        prev_r,    prev_nxt;
  logic              ov_r,      ov_nxt;
  logic [7:0]        obyte_r,   obyte_nxt;
  logic              olast_r,   olast_nxt;
  logic              odone_r,   odone_nxt;

  logic              can_emit;
  logic [AW-1:0]     wp_base;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        copy_byte;

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign can_emit  = !ov_r || !out_stall;
  assign wp_base   = head_cmd.clr_ptr ? '0 : wp_r;
  // A distance of one re-reads the slot written last cycle: take it from prev
  assign copy_byte = (first_r || dist_r != '0) ? rd_data : prev_r;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    dist_nxt  = dist_r;
    done_nxt  = done_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    ov_nxt    = ov_r && out_stall;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = wp_r;
    wr_data   = copy_byte;
    rd_en     = 1'b0;
    rd_addr   = wp_r - AW'(dist_r);
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (head_cmd.kind == CMD_LIT) begin
            // Emit a literal straight away
            if (can_emit) begin
              pop       = 1'b1;
              wr_en     = 1'b1;
              wr_addr   = wp_base;
              wr_data   = head_cmd.data[7:0];
              wp_nxt    = wp_base + AW'(1);
              ov_nxt    = 1'b1;
              obyte_nxt = head_cmd.data[7:0];
              olast_nxt = 1'b1;
              odone_nxt = head_cmd.done;
            end
          end else begin
            // Latch the copy and issue the first history read
            pop       = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = wp_base - AW'(head_cmd.data) - AW'(1);
            wp_nxt    = wp_base;
            cnt_nxt   = head_cmd.count;
            dist_nxt  = head_cmd.data;
            done_nxt  = head_cmd.done;
            first_nxt = 1'b1;
            state_nxt = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        // Emit one copied byte per cycle while the output is not stalled, and read ahead for the next one
        if (can_emit) begin
          wr_en     = 1'b1;
          wr_addr   = wp_r;
          wr_data   = copy_byte;
          wp_nxt    = wp_r + AW'(1);
          cnt_nxt   = cnt_r - LEN_W'(1);
          prev_nxt  = copy_byte;
          first_nxt = 1'b0;
          ov_nxt    = 1'b1;
          obyte_nxt = copy_byte;
          olast_nxt = (cnt_r == LEN_W'(1));
          odone_nxt = done_r && (cnt_r == LEN_W'(1));
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = wp_r - AW'(dist_r);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    dist_r  <= dist_nxt;
    done_r  <= done_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = obyte_r;
  assign out_last_of_run = olast_r;
  assign out_stream_done = odone_r;

endmodule
